// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the correction history table datapath (chc_dp).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHC_ASSERT(lbl, clk, rst, prop, msg)
`define CHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/chc_pkg.sv
// ----------------------------------------------------------------------------
// chc_pkg
// Shared widths, mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

  localparam int ENTRY_W     = 16;
  localparam int CORR_W      = 8;
  localparam int KEY_W       = 64;
  localparam int DEPTH_W     = 8;
  localparam int DIFF_W      = 16;
  localparam int DD_W        = DIFF_W + DEPTH_W;
  localparam int DEPTH_SHIFT = 3;
  localparam int CLAMP_DIV   = 4;
  localparam int SCALE_L     = 8;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic chg;
    logic mul;
    logic rcp;
    logic fix;
    logic wr;
    logic divs;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic query;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/chc_ctrl.sv
// ----------------------------------------------------------------------------
// chc_ctrl
// Sequencer: table clear after reset, then one word at a time through the
// read, gravity update and write back (update words only) and scaling steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chc_ctrl
  import chc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CHG  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_RCP  = 4'd4;
  localparam logic [3:0] ST_FIX  = 4'd5;
  localparam logic [3:0] ST_WR   = 4'd6;
  localparam logic [3:0] ST_DIVS = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ST_CHG;
        end
      end
      ST_CHG: begin
        cmd.chg    = 1'b1;
        state_next = sts.query ? ST_DIVS : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_RCP;
      end
      ST_RCP: begin
        cmd.rcp    = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.wr     = 1'b1;
        state_next = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.divs   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/chc_dp.sv
// ----------------------------------------------------------------------------
// chc_dp
// Datapath: entry memory, change scaling and clamp, gravity update through
// a reciprocal divider, scaling of the entry and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module chc_dp
  import chc_pkg::*;
#(
  parameter int TABLE_SIZE       = 16384,
  parameter int CORRECTION_LIMIT = 64,
  parameter int ENTRY_SCALE      = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic                      mode,
  input  logic                      side_to_move,
  input  logic [KEY_W-1:0]          key,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic signed [DIFF_W-1:0]  score_delta,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [CORR_W-1:0]  correction
);

  localparam int TW     = $clog2(TABLE_SIZE);
  localparam int AW     = TW + 1;
  localparam int DEPTH  = 2 * TABLE_SIZE;
  localparam int LIMIT  = CORRECTION_LIMIT * ENTRY_SCALE;
  localparam int BOUND  = LIMIT / CLAMP_DIV;
  localparam int CW     = $clog2(BOUND + 1) + 1;
  localparam int PW     = ENTRY_W + CW;
  localparam int NW     = PW + 3;
  localparam int SC_SH  = ENTRY_W + SCALE_L;
  localparam int SC_MW  = SC_SH + 1;
  localparam logic [63:0] RCP_FULL = (64'd1 << PW) / 64'(LIMIT);
  localparam logic [63:0] SC_FULL  =
    ((64'd1 << SC_SH) + 64'(ENTRY_SCALE) - 64'd1) / 64'(ENTRY_SCALE);
  localparam logic [PW:0]       RCP_V   = RCP_FULL[PW:0];
  localparam logic [SC_MW-1:0]  SC_M    = SC_FULL[SC_MW-1:0];
  localparam logic [PW-1:0]     LIMIT_V = PW'(LIMIT);
  localparam logic [PW:0]       TWO_L   = (PW + 1)'(2 * LIMIT);
  localparam logic signed [DD_W-1:0] BOUND_P = DD_W'(BOUND);
  localparam logic signed [DD_W-1:0] BOUND_N = -DD_W'(BOUND);
  localparam logic signed [DD_W-1:0] RND     = DD_W'((1 << DEPTH_SHIFT) - 1);
  localparam logic signed [NW-1:0]   SAT_HI  = NW'(32767);
  localparam logic signed [NW-1:0]   SAT_LO  = -NW'(32768);

  logic signed [ENTRY_W-1:0] mem [DEPTH];
  logic signed [ENTRY_W-1:0] mem_rd;
  logic [AW-1:0]             clr_cnt;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             idx;
  logic                      mode_q;
  logic signed [DD_W-1:0]    dd_prod;
  logic signed [CW-1:0]      chg;
  logic [CW-1:0]             mag;
  logic [PW-1:0]             prd;
  logic                      ent_neg;
  logic [PW-1:0]             q0;
  logic signed [PW:0]        qs;
  logic signed [ENTRY_W-1:0] val;
  logic [ENTRY_W-1:0]        sc_q;
  logic                      val_neg;

  logic signed [DD_W-1:0]    dd_adj;
  logic signed [DD_W-1:0]    dd_div;
  logic signed [DD_W-1:0]    dd_clamp;
  logic [ENTRY_W-1:0]        ent_mag;
  logic [2*PW:0]             rcp_full;
  logic [2*PW-1:0]           ql_full;
  logic [PW-1:0]             rem;
  logic [PW-1:0]             q;
  logic signed [NW-1:0]      nxt;
  logic signed [ENTRY_W-1:0] nxt_sat;
  logic [ENTRY_W-1:0]        val_mag;
  logic [ENTRY_W+SC_MW-1:0]  sc_full;
  logic [ENTRY_W-1:0]        corr_full;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [ENTRY_W-1:0] wdata;

  assign rd_addr = {side_to_move, key[TW-1:0]};

  assign dd_adj   = dd_prod + (dd_prod[DD_W-1] ? RND : '0);
  assign dd_div   = dd_adj >>> DEPTH_SHIFT;
  assign dd_clamp = (dd_div > BOUND_P) ? BOUND_P : ((dd_div < BOUND_N) ? BOUND_N : dd_div);

  assign ent_mag  = mem_rd[ENTRY_W-1] ? ENTRY_W'(-mem_rd) : ENTRY_W'(mem_rd);
  assign rcp_full = (2*PW+1)'(prd) * (2*PW+1)'(RCP_V);
  assign ql_full  = (2*PW)'(q0) * (2*PW)'(LIMIT_V);
  assign rem      = prd - ql_full[PW-1:0];
  assign q        = q0 + PW'(rem >= LIMIT_V);

  assign nxt      = NW'(mem_rd) + NW'(chg) - NW'(qs);
  assign nxt_sat  = (nxt > SAT_HI) ? ENTRY_W'(SAT_HI) :
                    ((nxt < SAT_LO) ? ENTRY_W'(SAT_LO) : ENTRY_W'(nxt));

  assign val_mag   = val[ENTRY_W-1] ? ENTRY_W'(-val) : ENTRY_W'(val);
  assign sc_full   = (ENTRY_W+SC_MW)'(val_mag) * (ENTRY_W+SC_MW)'(SC_M);
  assign corr_full = val_neg ? ENTRY_W'(-sc_q) : sc_q;

  assign we    = cmd.clr_step | cmd.wr;
  assign waddr = cmd.clr_step ? clr_cnt : idx;
  assign wdata = cmd.clr_step ? '0 : nxt_sat;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      mem_rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx     <= rd_addr;
      mode_q  <= mode;
      dd_prod <= DD_W'(score_delta) * $signed(DD_W'(depth));
    end
    if (cmd.chg) begin
      chg <= CW'(dd_clamp);
      mag <= dd_clamp[DD_W-1] ? CW'(-dd_clamp) : CW'(dd_clamp);
      val <= mem_rd;
    end
    if (cmd.mul) begin
      prd     <= PW'(ent_mag) * PW'(mag);
      ent_neg <= mem_rd[ENTRY_W-1];
    end
    if (cmd.rcp) begin
      q0 <= rcp_full[2*PW-1:PW];
    end
    if (cmd.fix) begin
      qs <= ent_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
    if (cmd.wr) begin
      val <= nxt_sat;
    end
    if (cmd.divs) begin
      sc_q    <= sc_full[SC_SH +: ENTRY_W];
      val_neg <= val[ENTRY_W-1];
    end
    if (cmd.load_out) begin
      correction <= corr_full[CORR_W-1:0];
    end
  end

  assign sts.query    = (mode_q == MODE_QUERY);
  assign sts.clr_last = (clr_cnt == AW'(DEPTH - 1));
  assign sts.out_free = !out_valid || !out_stall;

  `CHC_ASSERT(a_wr_update_only, clk, rst, cmd.wr |-> (mode_q == MODE_UPDATE), "write back on query word")
  `CHC_ASSERT(a_rcp_err, clk, rst, cmd.fix |-> ({1'b0, rem} < TWO_L), "reciprocal quotient off by more than one")
  `CHC_ASSERT_NEXT(a_entry_bound, clk, rst, cmd.wr, ($signed(val) <= LIMIT) && ($signed(val) >= -LIMIT), "entry beyond limit")
  `CHC_ASSERT(a_corr_range, clk, rst, out_valid |-> (($signed(correction) <= CORRECTION_LIMIT) && ($signed(correction) >= -CORRECTION_LIMIT)), "correction out of range")

endmodule

`default_nettype wire

// File: src/correction_history_table.sv
// ----------------------------------------------------------------------------
// correction_history_table
// Side and hash indexed correction table with gravity update and scaled read.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one word: mode, side_to_move, key,
// depth, score_delta. A word is taken when in_valid is high and in_stall low.
// Output channel out_valid/out_stall returns one correction word per input
// word, in order, once the receiver drops out_stall.
// Mode update: the entry is read, the clamped depth-weighted change is
// applied with the gravity term and written back. Mode query: the entry is
// read and scaled, with no write back. Either way the next word is taken
// only once the previous result is in the output register.
// The rate is set by the one-word-at-a-time read-modify-write of the entry
// memory and the multiply steps of the gravity divider.
// After reset in_stall stays high while all 2*TABLE_SIZE entries (32768 at
// the defaults) of the memory are cleared, one entry a cycle.
// While out_stall holds a finished word, one more word may be taken and
// worked on; it then waits until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module correction_history_table
  import chc_pkg::*;
#(
  parameter int TABLE_SIZE       = 16384,
  parameter int CORRECTION_LIMIT = 64,
  parameter int ENTRY_SCALE      = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic                      side_to_move,
  input  logic [KEY_W-1:0]          key,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic signed [DIFF_W-1:0]  score_delta,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [CORR_W-1:0]  correction
);

  cmd_t cmd;
  sts_t sts;

  chc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  chc_dp #(
    .TABLE_SIZE       (TABLE_SIZE),
    .CORRECTION_LIMIT (CORRECTION_LIMIT),
    .ENTRY_SCALE      (ENTRY_SCALE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .side_to_move (side_to_move),
    .key          (key),
    .depth        (depth),
    .score_delta  (score_delta),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .correction   (correction)
  );

endmodule

`default_nettype wire
